// ===== rtl/core/gbus_pkg.sv =====
// Shared package of the Gaussian blur and unsharp sharpen block: sizes, register
// indexes, mode codes, controller/datapath command and status structs, rounding.
// Depends on nothing.
package gbus_pkg;

    // Frame and ring geometry.
    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int ORIG_ROWS  = 8;
    localparam int BLUR_ROWS  = 15;
    localparam int ORIG_DEPTH = ORIG_ROWS * MAX_WIDTH;
    localparam int BLUR_DEPTH = BLUR_ROWS * MAX_WIDTH;
    localparam int ORIG_AW    = 14;
    localparam int BLUR_AW    = 15;
    localparam logic [3:0] RING_LAST = 4'd14;
    localparam int MAX_RESULTS = 8;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_WIDTH   = 3'd1,
        REG_HEIGHT  = 3'd2,
        REG_REACH   = 3'd3,
        REG_AMOUNT  = 3'd4,
        REG_W_LOW   = 3'd5,
        REG_W_HIGH  = 3'd6
    } t_reg_idx;

    // Mode codes; every other code passes pixels through.
    localparam logic [1:0] MODE_BLUR    = 2'd1;
    localparam logic [1:0] MODE_SHARPEN = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic h_start;
        logic h_issue;
        logic h_write;
        logic v_start;
        logic v_orig;
        logic v_issue;
        logic v_round;
        logic v_mul;
        logic v_final;
        logic push;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic h_pending;
        logic h_more;
        logic tap_last;
        logic reach_zero;
        logic pipe_busy;
        logic ready_more;
        logic pend_valid;
        logic out_free;
    } t_status;

    // Round a tap sum to U4.12, half up, saturated at all ones.
    function automatic logic [15:0] round16(input logic [35:0] sum);
        logic [36:0] t;
        t = {1'b0, sum} + 37'h8000;
        return (|t[36:32]) ? 16'hFFFF : t[31:16];
    endfunction

endpackage

// ===== rtl/core/gbus_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module gbus_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/gbus_ctrl.sv =====
// Controller state machine: sequences the row pass, the column pass and output.
// Depends on gbus_pkg.
module gbus_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  gbus_pkg::t_status i_status,
    output gbus_pkg::t_cmd   o_cmd
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_DISP   = 13'b0000000000010,
        ST_HSTART = 13'b0000000000100,
        ST_HTAP   = 13'b0000000001000,
        ST_HWAIT  = 13'b0000000010000,
        ST_HWR    = 13'b0000000100000,
        ST_CHECK  = 13'b0000001000000,
        ST_VORIG  = 13'b0000010000000,
        ST_VTAP   = 13'b0000100000000,
        ST_VWAIT  = 13'b0001000000000,
        ST_VRND   = 13'b0010000000000,
        ST_VMUL   = 13'b0100000000000,
        ST_VFIN   = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                n_state = i_status.h_pending ? ST_HSTART : ST_CHECK;
            end
            ST_HSTART: begin
                o_cmd.h_start = 1'b1;
                n_state = ST_HTAP;
            end
            ST_HTAP: begin
                o_cmd.h_issue = 1'b1;
                if (i_status.tap_last) begin
                    n_state = ST_HWAIT;
                end
            end
            ST_HWAIT: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_HWR;
                end
            end
            ST_HWR: begin
                o_cmd.h_write = 1'b1;
                n_state = i_status.h_more ? ST_HSTART : ST_CHECK;
            end
            ST_CHECK: begin
                // A pending result waits for room in the output register.
                if (!i_status.pend_valid || i_status.out_free) begin
                    o_cmd.push = i_status.pend_valid;
                    if (i_status.ready_more) begin
                        o_cmd.v_start = 1'b1;
                        n_state = ST_VORIG;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_VORIG: begin
                o_cmd.v_orig = 1'b1;
                n_state = i_status.reach_zero ? ST_VWAIT : ST_VTAP;
            end
            ST_VTAP: begin
                o_cmd.v_issue = 1'b1;
                if (i_status.tap_last) begin
                    n_state = ST_VWAIT;
                end
            end
            ST_VWAIT: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_VRND;
                end
            end
            ST_VRND: begin
                o_cmd.v_round = 1'b1;
                n_state = ST_VMUL;
            end
            ST_VMUL: begin
                o_cmd.v_mul = 1'b1;
                n_state = ST_VFIN;
            end
            ST_VFIN: begin
                o_cmd.v_final = 1'b1;
                n_state = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/gbus_dpath.sv =====
// Datapath: configuration registers, frame counters, line memories, tap
// multiply-accumulate, sharpen arithmetic and output register.
// Depends on gbus_pkg and gbus_ram.
module gbus_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gbus_pkg::t_cmd    i_cmd,
    output gbus_pkg::t_status o_status,
    input  logic [63:0]       s_tdata,   // red, green, blue, alpha from bit 0 up
    input  logic [0:0]        s_tuser,   // op
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic              m_tlast,
    output logic [0:0]        m_tuser,   // frame_done
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data
);

    localparam int CW = gbus_pkg::COL_W;
    localparam int RW = gbus_pkg::ROW_W;

    // Configuration registers.
    logic [1:0]  r_mode;
    logic [11:0] r_fw;
    logic [12:0] r_fh;
    logic [2:0]  r_reach;
    logic [15:0] r_amount;
    logic [63:0] r_wlo;
    logic [63:0] r_whi;

    // Frame counters.
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [3:0]    r_in_row15;
    logic          r_in_done;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;
    logic [3:0]    r_out_row15;

    // Row pass work.
    logic [2:0]    r_h_row3;
    logic [3:0]    r_h_row15;
    logic [CW-1:0] r_hx;
    logic [CW-1:0] r_hend;
    logic          r_h_pend;

    // Column pass work.
    logic signed [3:0] r_tap;
    logic [3:0]        r_sy15;
    logic [CW-1:0]     r_wox;
    logic [RW-1:0]     r_woy;
    logic              r_wdone;
    logic [3:0]        r_cnt;
    logic              r_stop;

    // Tap pipeline.
    logic        r_rv1;
    logic        r_cap1;
    logic        r_sel1;
    logic [15:0] r_wgt1;
    logic        r_rv2;
    logic [31:0] r_prod [4];
    logic [35:0] r_acc [4];
    logic [63:0] r_orig;
    logic [15:0] r_blur [4];
    logic signed [33:0] r_sprod [3];

    // Pending result and output register.
    logic [63:0] r_pend_data;
    logic        r_pend_done;
    logic        r_pend_valid;
    logic        r_m_valid;
    logic [63:0] r_m_data;
    logic        r_m_last;
    logic        r_m_done;

    logic [CW-1:0] w_w_m1;
    logic [RW-1:0] w_h_m1;
    logic [127:0]  w_wall;
    logic [3:0]    w_tap_mag;
    logic [15:0]   w_wgt;
    logic signed [12:0] w_hpos;
    logic [CW-1:0] w_hcol;
    logic signed [13:0] w_vpos;
    logic [12:0]   w_rr_sum;
    logic [RW-1:0] w_rr;
    logic [11:0]   w_cc_sum;
    logic [CW-1:0] w_cc;
    logic          w_ready;
    logic          w_ready_more;
    logic          w_out_free;
    logic          w_op_pixel;
    logic [4:0]    w_sy_wrap;
    logic [gbus_pkg::ORIG_AW-1:0] w_orig_raddr;
    logic [63:0]   w_orig_rdata;
    logic [63:0]   w_blur_rdata;
    logic [63:0]   w_rdata;
    logic [63:0]   w_hblur;
    logic signed [16:0] w_diff [3];
    logic [63:0]   w_final;

    assign o_cfg_ready = 1'b1;
    assign w_op_pixel  = ~s_tuser[0];

    // Effective frame bounds: zero counts as one, large values saturate.
    always_comb begin
        if (r_fw == 12'd0) begin
            w_w_m1 = '0;
        end else if (r_fw > 12'(gbus_pkg::MAX_WIDTH)) begin
            w_w_m1 = '1;
        end else begin
            w_w_m1 = CW'(r_fw - 12'd1);
        end
        if (r_fh == 13'd0) begin
            w_h_m1 = '0;
        end else if (r_fh[12]) begin
            w_h_m1 = '1;
        end else begin
            w_h_m1 = RW'(r_fh - 13'd1);
        end
    end

    // Weight of the current tap; taps mirror about the center.
    assign w_wall    = {r_whi, r_wlo};
    assign w_tap_mag = r_tap[3] ? (4'd0 - r_tap) : r_tap;
    assign w_wgt     = w_wall[16 * w_tap_mag[2:0] +: 16];

    // Row pass column, clamped to the frame.
    assign w_hpos = $signed({2'b00, r_hx}) + $signed({{9{r_tap[3]}}, r_tap});
    always_comb begin
        if (w_hpos < 0) begin
            w_hcol = '0;
        end else if (w_hpos > $signed({2'b00, w_w_m1})) begin
            w_hcol = w_w_m1;
        end else begin
            w_hcol = w_hpos[CW-1:0];
        end
    end

    // Column pass row position before clamping.
    assign w_vpos = $signed({2'b00, r_woy}) + $signed({{10{r_tap[3]}}, r_tap});

    // Output readiness: the last sample the next output needs has arrived.
    assign w_rr_sum = {1'b0, r_out_row} + 13'(r_reach);
    assign w_rr     = (w_rr_sum < {1'b0, w_h_m1}) ? w_rr_sum[RW-1:0] : w_h_m1;
    assign w_cc_sum = {1'b0, r_out_col} + 12'(r_reach);
    assign w_cc     = (w_cc_sum < {1'b0, w_w_m1}) ? w_cc_sum[CW-1:0] : w_w_m1;
    assign w_ready  = r_in_done || (r_in_row > w_rr) ||
                      ((r_in_row == w_rr) && (r_in_col > w_cc));
    assign w_ready_more = w_ready && !r_cnt[3] && !r_stop;
    assign w_out_free   = !r_m_valid || m_tready;

    assign w_sy_wrap = {1'b0, r_out_row15} + 5'd15 - 5'(r_reach);

    // Status toward the controller.
    always_comb begin
        o_status.h_pending  = r_h_pend;
        o_status.h_more     = (r_hx != r_hend);
        o_status.tap_last   = (r_tap == $signed({1'b0, r_reach}));
        o_status.reach_zero = (r_reach == 3'd0);
        o_status.pipe_busy  = r_rv1 | r_rv2;
        o_status.ready_more = w_ready_more;
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = w_out_free;
    end

    // Line memories.
    assign w_orig_raddr = i_cmd.v_orig ? {r_woy[2:0], r_wox} : {r_h_row3, w_hcol};

    gbus_ram #(
        .WIDTH (64),
        .DEPTH (gbus_pkg::ORIG_DEPTH)
    ) u_orig_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.accept && w_op_pixel),
        .i_wr_addr ({r_in_row[2:0], r_in_col}),
        .i_wr_data (s_tdata),
        .i_rd_en   (i_cmd.h_issue || i_cmd.v_orig),
        .i_rd_addr (w_orig_raddr),
        .o_rd_data (w_orig_rdata)
    );

    gbus_ram #(
        .WIDTH (64),
        .DEPTH (gbus_pkg::BLUR_DEPTH)
    ) u_blur_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.h_write),
        .i_wr_addr ({r_h_row15, r_hx}),
        .i_wr_data (w_hblur),
        .i_rd_en   (i_cmd.v_issue),
        .i_rd_addr ({r_sy15, r_wox}),
        .o_rd_data (w_blur_rdata)
    );

    assign w_rdata = r_sel1 ? w_blur_rdata : w_orig_rdata;
    assign w_hblur = {gbus_pkg::round16(r_acc[3]), gbus_pkg::round16(r_acc[2]),
                      gbus_pkg::round16(r_acc[1]), gbus_pkg::round16(r_acc[0])};

    // Sharpen difference and final channel selection.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_diff[c] = $signed({1'b0, r_orig[16*c +: 16]}) - $signed({1'b0, r_blur[c]});
        end
    end

    always_comb begin
        logic signed [34:0] t;
        logic [34:0]        u;
        t = '0;
        u = '0;
        for (int c = 0; c < 3; c++) begin
            if (r_mode == gbus_pkg::MODE_BLUR) begin
                w_final[16*c +: 16] = r_blur[c];
            end else if (r_mode == gbus_pkg::MODE_SHARPEN) begin
                t = $signed({7'b0, r_orig[16*c +: 16], 12'b0}) +
                    $signed({r_sprod[c][33], r_sprod[c]});
                u = 35'(t) + 35'd2048;
                if (t <= 0) begin
                    w_final[16*c +: 16] = 16'h0000;
                end else if (|u[34:28]) begin
                    w_final[16*c +: 16] = 16'hFFFF;
                end else begin
                    w_final[16*c +: 16] = u[27:12];
                end
            end else begin
                w_final[16*c +: 16] = r_orig[16*c +: 16];
            end
        end
        w_final[63:48] = (r_mode == gbus_pkg::MODE_BLUR) ? r_blur[3] : r_orig[63:48];
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 2'd0;
            r_fw     <= 12'd1920;
            r_fh     <= 13'd1080;
            r_reach  <= 3'd1;
            r_amount <= 16'd0;
            r_wlo    <= 64'd0;
            r_whi    <= 64'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gbus_pkg::REG_MODE:   r_mode   <= i_cfg_data[1:0];
                gbus_pkg::REG_WIDTH:  r_fw     <= i_cfg_data[11:0];
                gbus_pkg::REG_HEIGHT: r_fh     <= i_cfg_data[12:0];
                gbus_pkg::REG_REACH:  r_reach  <= i_cfg_data[2:0];
                gbus_pkg::REG_AMOUNT: r_amount <= i_cfg_data[15:0];
                gbus_pkg::REG_W_LOW:  r_wlo    <= i_cfg_data;
                gbus_pkg::REG_W_HIGH: r_whi    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame counters, row pass bookkeeping and output sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_row15  <= '0;
            r_in_done   <= 1'b0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_row15 <= '0;
            r_h_pend    <= 1'b0;
            r_cnt       <= '0;
            r_stop      <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_cnt  <= '0;
                r_stop <= 1'b0;
                r_h_pend <= 1'b0;
                if (w_op_pixel) begin
                    // A new frame drops whatever tail the last one still owed.
                    if (r_in_done) begin
                        r_in_done   <= 1'b0;
                        r_out_col   <= '0;
                        r_out_row   <= '0;
                        r_out_row15 <= '0;
                    end
                    r_h_row3  <= r_in_row[2:0];
                    r_h_row15 <= r_in_row15;
                    if (r_in_col >= w_w_m1) begin
                        r_hx     <= (r_in_col >= CW'(r_reach)) ? r_in_col - CW'(r_reach) : '0;
                        r_hend   <= r_in_col;
                        r_h_pend <= 1'b1;
                        r_in_col <= '0;
                        if (r_in_row >= w_h_m1) begin
                            r_in_row   <= '0;
                            r_in_row15 <= '0;
                            r_in_done  <= 1'b1;
                        end else begin
                            r_in_row   <= r_in_row + RW'(1);
                            r_in_row15 <= (r_in_row15 == gbus_pkg::RING_LAST) ?
                                          4'd0 : r_in_row15 + 4'd1;
                        end
                    end else begin
                        if (r_in_col >= CW'(r_reach)) begin
                            r_hx     <= r_in_col - CW'(r_reach);
                            r_hend   <= r_in_col - CW'(r_reach);
                            r_h_pend <= 1'b1;
                        end
                        r_in_col <= r_in_col + CW'(1);
                    end
                end
            end
            if (i_cmd.h_write && (r_hx != r_hend)) begin
                r_hx <= r_hx + CW'(1);
            end
            // Start of an output pixel: take its position and step past it.
            if (i_cmd.v_start) begin
                r_wox   <= r_out_col;
                r_woy   <= r_out_row;
                r_wdone <= (r_out_col >= w_w_m1) && (r_out_row >= w_h_m1);
                r_cnt   <= r_cnt + 4'd1;
                if ((r_out_col >= w_w_m1) && (r_out_row >= w_h_m1)) begin
                    r_out_col   <= '0;
                    r_out_row   <= '0;
                    r_out_row15 <= '0;
                    r_in_done   <= 1'b0;
                    r_stop      <= 1'b1;
                end else if (r_out_col >= w_w_m1) begin
                    r_out_col   <= '0;
                    r_out_row   <= r_out_row + RW'(1);
                    r_out_row15 <= (r_out_row15 == gbus_pkg::RING_LAST) ?
                                   4'd0 : r_out_row15 + 4'd1;
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    // Tap position and the ring row of the current column tap.
    always_ff @(posedge i_clk) begin
        if (i_cmd.h_start) begin
            r_tap <= -$signed({1'b0, r_reach});
        end
        if (i_cmd.v_start) begin
            r_tap <= -$signed({1'b0, r_reach});
            if (r_out_row >= RW'(r_reach)) begin
                r_sy15 <= (r_out_row15 >= 4'(r_reach)) ?
                          r_out_row15 - 4'(r_reach) : w_sy_wrap[3:0];
            end else begin
                r_sy15 <= '0;
            end
        end
        if (i_cmd.h_issue || i_cmd.v_issue) begin
            r_tap <= r_tap + 4'sd1;
        end
        // The clamped row moves only while the next position is inside the frame.
        if (i_cmd.v_issue && (w_vpos >= 0) && (w_vpos < $signed({2'b00, w_h_m1}))) begin
            r_sy15 <= (r_sy15 == gbus_pkg::RING_LAST) ? 4'd0 : r_sy15 + 4'd1;
        end
    end

    // Read, multiply and accumulate pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv1 <= 1'b0;
            r_rv2 <= 1'b0;
        end else begin
            r_rv1 <= i_cmd.h_issue || i_cmd.v_issue || i_cmd.v_orig;
            r_rv2 <= r_rv1 && !r_cap1;
        end
        r_cap1 <= i_cmd.v_orig;
        r_sel1 <= i_cmd.v_issue;
        r_wgt1 <= w_wgt;
        if (r_rv1 && r_cap1) begin
            r_orig <= w_rdata;
        end
        for (int c = 0; c < 4; c++) begin
            r_prod[c] <= w_rdata[16*c +: 16] * r_wgt1;
            if (i_cmd.h_start || i_cmd.v_start) begin
                r_acc[c] <= '0;
            end else if (r_rv2) begin
                r_acc[c] <= r_acc[c] + 36'(r_prod[c]);
            end
        end
    end

    // Column blur rounding and sharpen products.
    always_ff @(posedge i_clk) begin
        if (i_cmd.v_round) begin
            for (int c = 0; c < 4; c++) begin
                r_blur[c] <= (r_reach == 3'd0) ? r_orig[16*c +: 16] :
                             gbus_pkg::round16(r_acc[c]);
            end
        end
        if (i_cmd.v_mul) begin
            for (int c = 0; c < 3; c++) begin
                r_sprod[c] <= $signed({1'b0, r_amount}) * w_diff[c];
            end
        end
    end

    // Pending result and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cmd.v_final) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.push) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.push) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (i_cmd.v_final) begin
            r_pend_data <= w_final;
            r_pend_done <= r_wdone;
        end
        if (i_cmd.push) begin
            r_m_data <= r_pend_data;
            r_m_last <= !w_ready_more;
            r_m_done <= r_pend_done;
        end
    end

    assign m_tvalid   = r_m_valid;
    assign m_tdata    = r_m_data;
    assign m_tlast    = r_m_last;
    assign m_tuser[0] = r_m_done;

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> w_out_free)
        else $error("result pushed into a full output register");
    a_write_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.h_write |-> !(r_rv1 || r_rv2))
        else $error("row blur written before its taps were summed");
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(gbus_pkg::MAX_RESULTS))
        else $error("more results than allowed for one request");
    a_pend_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.v_final |-> !r_pend_valid)
        else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/core/gaussian_blur_unsharp_sharpen.sv =====
// Top level of the separable Gaussian blur and unsharp sharpen block.
// Depends on gbus_pkg, gbus_ctrl, gbus_dpath and gbus_ram.
//
// RGBA pixels (U4.12) enter in raster order and are blurred along the row and
// then down the column with edge clamping; the block outputs the blur, the
// sharpened pixel or the original pixel according to the mode register. Each
// request is worked on alone: it row-blurs each column it completes (at most
// one, or up to reach+1 at a row end), then releases up to eight results. Its
// pace is set by the one read port of each line memory, serving one filter
// tap per cycle through a shared multiply-accumulate unit. Results wait in a
// pending register and an output register, so a stalled consumer holds the
// block only when a second result is ready. Drain requests (tuser set) flush
// the rows owed after the last pixel of a frame. The line memories need no
// clearing after reset. The user must write configuration through the write
// channel only while the block is idle; the block itself does not enforce it.
module gaussian_blur_unsharp_sharpen (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // red, green, blue, alpha from bit 0 up
    input  logic [0:0]  s_tuser,     // op: 0 pixel, 1 drain
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // out_red, out_green, out_blue, out_alpha
    output logic        m_tlast,     // last_of_run
    output logic [0:0]  m_tuser,     // frame_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    gbus_pkg::t_cmd    w_cmd;
    gbus_pkg::t_status w_status;

    // Sequencer.
    gbus_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Filter datapath.
    gbus_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
